// ----- rtl/core/lrz_pkg.sv -----
// ----------------------------------------------------------------------------
// lrz_pkg
// Shared widths, field offsets, codes and handshake structs of the line
// rasterizer with depth.
// ----------------------------------------------------------------------------
package lrz_pkg;

	// field widths
	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 32;
	localparam int COLOR_BITS = 24;

	// derived datapath widths
	localparam int DELTA_BITS   = COORD_BITS + 1;
	localparam int ERR_BITS     = COORD_BITS + 4;
	localparam int DZ_BITS      = DEPTH_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(DZ_BITS);

	// input item packing, first field in the lowest bits
	localparam int OFS_SX  = 0;
	localparam int OFS_SY  = OFS_SX + COORD_BITS;
	localparam int OFS_SZ  = OFS_SY + COORD_BITS;
	localparam int OFS_EX  = OFS_SZ + DEPTH_BITS;
	localparam int OFS_EY  = OFS_EX + COORD_BITS;
	localparam int OFS_EZ  = OFS_EY + COORD_BITS;
	localparam int OFS_COL = OFS_EZ + DEPTH_BITS;
	localparam int IN_RAW_BITS  = OFS_COL + COLOR_BITS;
	localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;

	// result item packing
	localparam int OUT_RAW_BITS  = 2 * COORD_BITS + DEPTH_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	// item kind carried on tuser
	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_TICK  = 1'b1
	} func_t;

	// walk direction of the current line
	typedef enum logic [1:0] {
		MODE_X_UP   = 2'd0,
		MODE_Y_UP   = 2'd1,
		MODE_X_DOWN = 2'd2,
		MODE_Y_DOWN = 2'd3
	} mode_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic setup;
		logic div_go;
		logic step_wr;
		logic tick;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic div_done;
	} status_t;

endpackage

// ----- rtl/core/lrz_div.sv -----
// ----------------------------------------------------------------------------
// lrz_div
// Restoring divider, one quotient bit per cycle: magnitude of the signed
// depth delta over the unsigned major-axis delta. A zero divisor gives 0.
// ----------------------------------------------------------------------------
module lrz_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic signed [lrz_pkg::DZ_BITS-1:0]   dividend,
	input  logic        [lrz_pkg::COORD_BITS-1:0] divisor,
	output logic                                 done,
	output logic        [lrz_pkg::DZ_BITS-1:0]   quotient,
	output logic                                 neg
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [lrz_pkg::DIV_CNT_BITS-1:0]      cnt_q;
	logic [lrz_pkg::COORD_BITS-1:0]        rem_q;
	logic [lrz_pkg::DZ_BITS-1:0]           quo_q;
	logic [lrz_pkg::COORD_BITS-1:0]        dsr_q;
	logic                                  neg_q;
	logic                                  zero_q;

	logic [lrz_pkg::COORD_BITS:0]          trial;
	logic [lrz_pkg::COORD_BITS:0]          diff;
	logic                                  fits;
	logic [lrz_pkg::DZ_BITS-1:0]           mag;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, quo_q[lrz_pkg::DZ_BITS-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
		mag   = dividend[lrz_pkg::DZ_BITS-1] ? (-dividend) : dividend;
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= lrz_pkg::DIV_CNT_BITS'(lrz_pkg::DZ_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// shift quotient bits in, keep the remainder
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			quo_q  <= mag;
			dsr_q  <= divisor;
			neg_q  <= dividend[lrz_pkg::DZ_BITS-1];
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			rem_q <= fits ? diff[lrz_pkg::COORD_BITS-1:0] : trial[lrz_pkg::COORD_BITS-1:0];
			quo_q <= {quo_q[lrz_pkg::DZ_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : quo_q;
	assign neg      = neg_q;

endmodule

// ----- rtl/core/lrz_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrz_ctrl
// Controller: takes input items, sequences line setup and the z step
// division, and issues datapath commands.
// ----------------------------------------------------------------------------
module lrz_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	output logic             s_tready,
	input  lrz_pkg::status_t status,
	output lrz_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_SETUP = 3'b010,
		ST_DIV   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				s_tready = status.out_free;
				if (s_tvalid && status.out_free) begin
					if (s_tuser == lrz_pkg::FUNC_START) begin
						cmd.load = 1'b1;
						state_d  = ST_SETUP;
					end else begin
						cmd.tick = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup  = 1'b1;
				cmd.div_go = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.step_wr = 1'b1;
					state_d     = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/lrz_datapath.sv -----
// ----------------------------------------------------------------------------
// lrz_datapath
// Line state, endpoint setup, Bresenham step, depth accumulation and the
// output register.
// ----------------------------------------------------------------------------
module lrz_datapath (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  lrz_pkg::cmd_t                             cmd,
	input  logic [lrz_pkg::IN_DATA_BITS-1:0]          s_tdata,
	input  logic                                      m_tready,
	output logic                                      m_tvalid,
	output logic [lrz_pkg::OUT_DATA_BITS-1:0]         m_tdata,
	output logic                                      m_tlast,
	output logic                                      out_free,
	output logic signed [lrz_pkg::DZ_BITS-1:0]        div_dividend,
	output logic        [lrz_pkg::COORD_BITS-1:0]     div_divisor,
	input  logic        [lrz_pkg::DZ_BITS-1:0]        div_quotient,
	input  logic                                      div_neg
);

	localparam int CB = lrz_pkg::COORD_BITS;
	localparam int DB = lrz_pkg::DEPTH_BITS;
	localparam int EB = lrz_pkg::ERR_BITS;
	localparam int TB = lrz_pkg::DELTA_BITS;

	// line state
	logic signed [CB-1:0]            cur_x_q;
	logic signed [CB-1:0]            cur_y_q;
	logic        [DB-1:0]            cur_z_q;
	logic signed [CB-1:0]            stop_q;
	logic signed [CB-1:0]            end_x_q;
	logic signed [CB-1:0]            end_y_q;
	logic signed [EB-1:0]            err_q;
	logic signed [TB-1:0]            dx_q;
	logic signed [TB-1:0]            dy_q;
	logic signed [lrz_pkg::DZ_BITS-1:0] dz_q;
	logic        [DB-1:0]            z_step_q;
	lrz_pkg::mode_t                  mode_q;
	logic [lrz_pkg::COLOR_BITS-1:0]  color_q;
	logic                            busy_q;

	// output register
	logic                            out_valid_q;
	logic signed [CB-1:0]            out_x_q;
	logic signed [CB-1:0]            out_y_q;
	logic        [DB-1:0]            out_z_q;
	logic [lrz_pkg::COLOR_BITS-1:0]  out_color_q;
	logic                            out_last_q;

	// load decode
	logic signed [CB-1:0]            sx, sy, ex, ey;
	logic signed [DB-1:0]            sz, ez;
	logic                            swap;
	logic signed [CB-1:0]            x0, y0, x1, y1;
	logic signed [DB-1:0]            z0, z1;

	// setup decode
	logic signed [TB-1:0]            ndy;
	lrz_pkg::mode_t                  mode_d;
	logic signed [EB-1:0]            dx_e, dy_e;
	logic signed [EB-1:0]            err_init;

	// step decode
	logic                            x_major;
	logic                            last;
	logic signed [EB-1:0]            err_next;
	logic                            step_x, step_y;
	logic [DB-1:0]                   quo_lo;

	// unpack and order the endpoints so x never decreases
	always_comb begin
		sx   = $signed(s_tdata[lrz_pkg::OFS_SX +: CB]);
		sy   = $signed(s_tdata[lrz_pkg::OFS_SY +: CB]);
		sz   = $signed(s_tdata[lrz_pkg::OFS_SZ +: DB]);
		ex   = $signed(s_tdata[lrz_pkg::OFS_EX +: CB]);
		ey   = $signed(s_tdata[lrz_pkg::OFS_EY +: CB]);
		ez   = $signed(s_tdata[lrz_pkg::OFS_EZ +: DB]);
		swap = sx > ex;
		x0   = swap ? ex : sx;
		y0   = swap ? ey : sy;
		z0   = swap ? ez : sz;
		x1   = swap ? sx : ex;
		y1   = swap ? sy : ey;
		z1   = swap ? sz : ez;
	end

	// pick the octant mode, initial error and division operands
	always_comb begin
		ndy  = -dy_q;
		dx_e = $signed({{(EB-TB){dx_q[TB-1]}}, dx_q});
		dy_e = $signed({{(EB-TB){dy_q[TB-1]}}, dy_q});
		if (dy_q > $signed(TB'(0))) begin
			mode_d = (dx_q > dy_q) ? lrz_pkg::MODE_X_UP : lrz_pkg::MODE_Y_UP;
		end else begin
			mode_d = (dx_q > ndy) ? lrz_pkg::MODE_X_DOWN : lrz_pkg::MODE_Y_DOWN;
		end
		unique case (mode_d)
			lrz_pkg::MODE_X_UP: begin
				err_init    = dy_e + dy_e - dx_e;
				div_divisor = dx_q[CB-1:0];
			end
			lrz_pkg::MODE_Y_UP: begin
				err_init    = dy_e - dx_e - dx_e;
				div_divisor = dy_q[CB-1:0];
			end
			lrz_pkg::MODE_X_DOWN: begin
				err_init    = dy_e + dy_e + dx_e;
				div_divisor = dx_q[CB-1:0];
			end
			default: begin
				err_init    = dy_e + dx_e + dx_e;
				div_divisor = ndy[CB-1:0];
			end
		endcase
		div_dividend = dz_q;
	end

	// Bresenham step of the current pixel
	always_comb begin
		x_major = (mode_q == lrz_pkg::MODE_X_UP) || (mode_q == lrz_pkg::MODE_X_DOWN);
		last    = x_major ? (cur_x_q == stop_q) : (cur_y_q == stop_q);
		step_x  = 1'b0;
		step_y  = 1'b0;
		unique case (mode_q)
			lrz_pkg::MODE_X_UP: begin
				step_x = 1'b1;
				if (err_q < 0) begin
					err_next = err_q + dy_e + dy_e;
				end else begin
					step_y   = 1'b1;
					err_next = err_q + dy_e + dy_e - dx_e - dx_e;
				end
			end
			lrz_pkg::MODE_Y_UP: begin
				step_y = 1'b1;
				if (err_q > 0) begin
					err_next = err_q - dx_e - dx_e;
				end else begin
					step_x   = 1'b1;
					err_next = err_q + dy_e + dy_e - dx_e - dx_e;
				end
			end
			lrz_pkg::MODE_X_DOWN: begin
				step_x = 1'b1;
				if (err_q > 0) begin
					err_next = err_q + dy_e + dy_e;
				end else begin
					step_y   = 1'b1;
					err_next = err_q + dy_e + dy_e + dx_e + dx_e;
				end
			end
			default: begin
				step_y = 1'b1;
				if (err_q < 0) begin
					err_next = err_q + dx_e + dx_e;
				end else begin
					step_x   = 1'b1;
					err_next = err_q + dy_e + dy_e + dx_e + dx_e;
				end
			end
		endcase
	end

	assign quo_lo = div_quotient[DB-1:0];

	// control state: line active flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				busy_q <= 1'b1;
			end else if (cmd.tick && busy_q && last) begin
				busy_q <= 1'b0;
			end
			if (cmd.tick && busy_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line state updates
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= x0;
			cur_y_q <= y0;
			cur_z_q <= z0;
			end_x_q <= x1;
			end_y_q <= y1;
			dx_q    <= $signed({x1[CB-1], x1}) - $signed({x0[CB-1], x0});
			dy_q    <= $signed({y1[CB-1], y1}) - $signed({y0[CB-1], y0});
			dz_q    <= $signed({z1[DB-1], z1}) - $signed({z0[DB-1], z0});
			color_q <= s_tdata[lrz_pkg::OFS_COL +: lrz_pkg::COLOR_BITS];
		end else if (cmd.setup) begin
			mode_q <= mode_d;
			err_q  <= err_init;
			stop_q <= ((mode_d == lrz_pkg::MODE_X_UP) || (mode_d == lrz_pkg::MODE_X_DOWN))
				? end_x_q : end_y_q;
		end else if (cmd.step_wr) begin
			z_step_q <= div_neg ? (-quo_lo) : quo_lo;
		end else if (cmd.tick && busy_q) begin
			cur_z_q <= cur_z_q + z_step_q;
			err_q   <= err_next;
			if (step_x) begin
				cur_x_q <= cur_x_q + 1'b1;
			end
			if (step_y) begin
				if (mode_q == lrz_pkg::MODE_Y_UP || mode_q == lrz_pkg::MODE_X_UP) begin
					cur_y_q <= cur_y_q + 1'b1;
				end else begin
					cur_y_q <= cur_y_q - 1'b1;
				end
			end
		end
	end

	// capture the emitted pixel
	always_ff @(posedge clk) begin
		if (cmd.tick && busy_q) begin
			out_x_q     <= cur_x_q;
			out_y_q     <= cur_y_q;
			out_z_q     <= cur_z_q;
			out_color_q <= color_q;
			out_last_q  <= last;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = lrz_pkg::OUT_DATA_BITS'({out_color_q, out_z_q, out_y_q, out_x_q});

endmodule

// ----- rtl/core/line_rasterizer_with_depth_core.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_with_depth_core
// Bresenham line walker with linear Q16.16 depth interpolation.
// ----------------------------------------------------------------------------
// A start item (tuser = 0) loads both endpoints and the color and returns no
// pixel; the block then keeps s_tready low while it sets up the octant and
// runs the z step division, one quotient bit per cycle over the 33-bit depth
// delta in a restoring divider. After that each tick item (tuser = 1)
// returns one pixel through a single output register; ticks can follow
// back to back as long as m_tready keeps the register draining. The last
// pixel of a line has tlast set, and ticks taken with no line active return
// nothing. A start item drops any line in progress.
module line_rasterizer_with_depth_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, line_color
	input  logic [lrz_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// func
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_x, pixel_y, pixel_z, pixel_color
	output logic [lrz_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	output logic                                m_tlast
);

	lrz_pkg::cmd_t                         cmd;
	lrz_pkg::status_t                      status;
	logic                                  out_free;
	logic                                  div_done;
	logic signed [lrz_pkg::DZ_BITS-1:0]    div_dividend;
	logic        [lrz_pkg::COORD_BITS-1:0] div_divisor;
	logic        [lrz_pkg::DZ_BITS-1:0]    div_quotient;
	logic                                  div_neg;

	assign status.out_free = out_free;
	assign status.div_done = div_done;

	lrz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lrz_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.s_tdata      (s_tdata),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.out_free     (out_free),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_quotient (div_quotient),
		.div_neg      (div_neg)
	);

	lrz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient),
		.neg      (div_neg)
	);

endmodule

// ----- rtl/core/lrz_checker.sv -----
// ----------------------------------------------------------------------------
// lrz_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lrz_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [lrz_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input logic                                m_tlast
);

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output item changed");

	// never take input while the output register is stuck
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken with no room for a result");

	// a start item blocks input during setup
	a_start_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == lrz_pkg::FUNC_START) |=> !s_tready)
		else $error("input taken during line setup");

	// a new pixel appears only right after an accepted tick
	a_pixel_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == lrz_pkg::FUNC_TICK)))
		else $error("pixel without a tick");

endmodule

bind line_rasterizer_with_depth_core lrz_checker u_lrz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- sim/line_rasterizer_with_depth_core_test.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_with_depth_core_test
// Self-checking bench for the line rasterizer with depth. Drives start and
// tick items from a queue with bursty gaps and pulls pixels under a
// shifting stall pattern. A built-in line walker predicts every pixel, and
// each pixel is checked field by field against it.
// ----------------------------------------------------------------------------
module line_rasterizer_with_depth_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lrz_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int DW = DEPTH_BITS;

	// result item packing, first field in the lowest bits
	localparam int PX_OFS = 0;
	localparam int PY_OFS = PX_OFS + CW;
	localparam int PZ_OFS = PY_OFS + CW;
	localparam int PC_OFS = PZ_OFS + DW;

	localparam int RANDOM_ITEMS = 800;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 1000000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] depth_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	typedef struct {
		func_t  func;
		coord_t sx;
		coord_t sy;
		depth_t sz;
		coord_t ex;
		coord_t ey;
		depth_t ez;
		color_t color;
		bit     hold;   // wait for all pending pixels before sending
	} stim_t;

	typedef struct {
		coord_t        x;
		coord_t        y;
		logic [DW-1:0] z;
		color_t        color;
		logic          last;
	} pixel_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic                     s_tuser = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tlast;

	stim_t  stim_q[$];
	pixel_t pixel_q[$];
	stim_t  shown;
	int     total_items = 0;
	int     items_taken = 0;
	int     error_count = 0;
	int     cycle_count = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_phase = 0;
	int     phase_left = 0;

	// line walker state
	int            walk_x = 0;
	int            walk_y = 0;
	int            stop_at = 0;
	int            err = 0;
	int            ddx = 0;
	int            ddy = 0;
	logic [DW-1:0] walk_z = '0;
	logic [DW-1:0] z_inc = '0;
	mode_t         walk_mode = MODE_X_UP;
	color_t        held_color = '0;
	bit            line_active = 1'b0;

	line_rasterizer_with_depth_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Advance the line walker by one accepted item, queueing any pixel
	function automatic void walk_line(input stim_t it);
		int     x0, y0, x1, y1, t;
		longint z0, z1, tz, dz, q, major;
		pixel_t px;
		bit     at_end;
		if (it.func == FUNC_START) begin
			x0 = it.sx;
			y0 = it.sy;
			z0 = it.sz;
			x1 = it.ex;
			y1 = it.ey;
			z1 = it.ez;
			// keep x non-decreasing along the line
			if (x0 > x1) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
				tz = z0; z0 = z1; z1 = tz;
			end
			ddx = x1 - x0;
			ddy = y1 - y0;
			dz = z1 - z0;
			walk_x = x0;
			walk_y = y0;
			walk_z = depth_t'(z0);
			held_color = it.color;
			if (ddy > 0) begin
				if (ddx > ddy) begin
					walk_mode = MODE_X_UP;
					err = 2 * ddy - ddx;
					major = ddx;
					stop_at = x1;
				end else begin
					walk_mode = MODE_Y_UP;
					err = ddy - 2 * ddx;
					major = ddy;
					stop_at = y1;
				end
			end else if (ddx > -ddy) begin
				walk_mode = MODE_X_DOWN;
				err = 2 * ddy + ddx;
				major = ddx;
				stop_at = x1;
			end else begin
				walk_mode = MODE_Y_DOWN;
				err = ddy + 2 * ddx;
				major = -ddy;
				stop_at = y1;
			end
			q = (major > 0) ? dz / major : 0;
			z_inc = q[DW-1:0];
			line_active = 1'b1;
		end else if (line_active) begin
			at_end = (walk_mode == MODE_X_UP || walk_mode == MODE_X_DOWN) ?
				(walk_x == stop_at) : (walk_y == stop_at);
			px.x = coord_t'(walk_x);
			px.y = coord_t'(walk_y);
			px.z = walk_z;
			px.color = held_color;
			px.last = at_end;
			pixel_q.push_back(px);
			walk_z = walk_z + z_inc;
			case (walk_mode)
				MODE_X_UP: begin
					if (err < 0) begin
						err += 2 * ddy;
					end else begin
						walk_y++;
						err += 2 * (ddy - ddx);
					end
					walk_x++;
				end
				MODE_Y_UP: begin
					if (err > 0) begin
						err -= 2 * ddx;
					end else begin
						walk_x++;
						err += 2 * (ddy - ddx);
					end
					walk_y++;
				end
				MODE_X_DOWN: begin
					if (err > 0) begin
						err += 2 * ddy;
					end else begin
						walk_y--;
						err += 2 * (ddy + ddx);
					end
					walk_x++;
				end
				default: begin
					if (err < 0) begin
						err += 2 * ddx;
					end else begin
						walk_x++;
						err += 2 * (ddy + ddx);
					end
					walk_y--;
				end
			endcase
			if (at_end)
				line_active = 1'b0;
		end
	endfunction

	task automatic queue_start(input int x0, input int y0, input depth_t z0,
			input int x1, input int y1, input depth_t z1, input color_t col,
			input bit hold);
		stim_t it;
		it.func = FUNC_START;
		it.sx = coord_t'(x0);
		it.sy = coord_t'(y0);
		it.sz = z0;
		it.ex = coord_t'(x1);
		it.ey = coord_t'(y1);
		it.ez = z1;
		it.color = col;
		it.hold = hold;
		stim_q.push_back(it);
	endtask

	// Tick items carry random filler in the unused fields
	task automatic queue_ticks(input int n);
		stim_t it;
		repeat (n) begin
			it.func = FUNC_TICK;
			it.sx = coord_t'($urandom);
			it.sy = coord_t'($urandom);
			it.sz = depth_t'($urandom);
			it.ex = coord_t'($urandom);
			it.ey = coord_t'($urandom);
			it.ez = depth_t'($urandom);
			it.color = color_t'($urandom);
			it.hold = 1'b0;
			stim_q.push_back(it);
		end
	endtask

	// Step off the base point, folding back if the range would be left
	function automatic int fold_into_range(input int base, input int d);
		int v;
		v = base + d;
		if (v > 2047 || v < -2048)
			v = base - d;
		return v;
	endfunction

	// Drive items in bursts with random gaps
	always @(posedge clk) begin : drive
		logic [IN_DATA_BITS-1:0] word;
		logic give;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			give = s_tvalid;
			if (s_tvalid && s_tready) begin
				walk_line(shown);
				items_taken++;
				give = 1'b0;
			end
			if (!give) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() > 0 &&
						!(stim_q[0].hold && pixel_q.size() > 0)) begin
					shown = stim_q.pop_front();
					word = '0;
					word[OFS_SX +: CW] = shown.sx;
					word[OFS_SY +: CW] = shown.sy;
					word[OFS_SZ +: DW] = shown.sz;
					word[OFS_EX +: CW] = shown.ex;
					word[OFS_EY +: CW] = shown.ey;
					word[OFS_EZ +: DW] = shown.ez;
					word[OFS_COL +: COLOR_BITS] = shown.color;
					s_tdata <= word;
					s_tuser <= shown.func;
					give = 1'b1;
					// end the burst and pick the next gap
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
			s_tvalid <= give;
		end
	end

	// Check each pixel and apply the stall pattern
	always @(posedge clk) begin : check
		pixel_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[PX_OFS +: CW];
				got.y = m_tdata[PY_OFS +: CW];
				got.z = m_tdata[PZ_OFS +: DW];
				got.color = m_tdata[PC_OFS +: COLOR_BITS];
				got.last = m_tlast;
				if (pixel_q.size() == 0) begin
					flag_error($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
				end else begin
					want = pixel_q.pop_front();
					if (got.x !== want.x)
						flag_error($sformatf("pixel_x %0d, want %0d", got.x, want.x));
					if (got.y !== want.y)
						flag_error($sformatf("pixel_y %0d, want %0d", got.y, want.y));
					if (got.z !== want.z)
						flag_error($sformatf("pixel_z %h, want %h", got.z, want.z));
					if (got.color !== want.color)
						flag_error($sformatf("pixel_color %h, want %h", got.color, want.color));
					if (got.last !== want.last)
						flag_error($sformatf("last_pixel %b, want %b", got.last, want.last));
				end
			end
			// rotate between free flow, light stalls and heavy stalls
			if (phase_left == 0) begin
				stall_phase = $urandom_range(0, 2);
				phase_left = $urandom_range(16, 200);
			end else begin
				phase_left--;
			end
			case (stall_phase)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("line_rasterizer_with_depth_core_test NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int planned, span, dx, dy, x0, y0, x1, y1, r;

		// tick with no line active
		queue_ticks(1);
		// single-point line, then a tick after it ends
		queue_start(0, 0, 32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0);
		queue_ticks(2);
		// full-range diagonal, dropped by the next start
		queue_start(-2048, -2048, 32'h8000_0000, 2047, 2047, 32'h7FFF_FFFF, 24'h000000, 1'b0);
		queue_ticks(3);
		// swapped endpoints, steep falling line at full range
		queue_start(2047, -2048, 32'h7FFF_FFFF, -2048, 2047, 32'h8000_0000, 24'hA5A5A5,
			1'b0);
		queue_ticks(2);
		// shallow rising line, sent only once all pixels are in
		queue_start(0, 0, 32'h0000_0000, 3, 1, 32'h0003_0000, 24'h123456, 1'b1);
		queue_ticks(4);
		// shallow falling line with swapped endpoints
		queue_start(13, 4, 32'hFFFF_0000, 10, 5, 32'h0002_8000, 24'h5A5A5A, 1'b0);
		queue_ticks(4);
		// steep rising line
		queue_start(0, 0, 32'h7FFF_0000, 1, 3, 32'h8000_FFFF, 24'hFEDCBA, 1'b0);
		queue_ticks(4);

		planned = 0;
		while (planned < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				// well-formed line walked to its end, mostly short
				span = ($urandom_range(0, 29) == 0) ? 300 : 12;
				dx = int'($urandom_range(0, 2 * span)) - span;
				dy = int'($urandom_range(0, 2 * span)) - span;
				x0 = int'($urandom_range(0, 4095)) - 2048;
				y0 = int'($urandom_range(0, 4095)) - 2048;
				x1 = fold_into_range(x0, dx);
				y1 = fold_into_range(y0, dy);
				dx = (x1 > x0) ? x1 - x0 : x0 - x1;
				dy = (y1 > y0) ? y1 - y0 : y0 - y1;
				queue_start(x0, y0, depth_t'($urandom), x1, y1, depth_t'($urandom),
					color_t'($urandom), $urandom_range(0, 19) == 0);
				queue_ticks(((dx > dy) ? dx : dy) + 1);
				planned += ((dx > dy) ? dx : dy) + 2;
			end else if (r < 92) begin
				// arbitrary line cut short by whatever follows
				queue_start(int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048, depth_t'($urandom),
					int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048, depth_t'($urandom),
					color_t'($urandom), 1'b0);
				r = $urandom_range(0, 5);
				queue_ticks(r);
				planned += r + 1;
			end else begin
				// stray ticks
				r = $urandom_range(1, 3);
				queue_ticks(r);
				planned += r;
			end
		end
		total_items = stim_q.size();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (items_taken < total_items || pixel_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("line_rasterizer_with_depth_core_test OK");
		else
			$display("line_rasterizer_with_depth_core_test NOT OK");
		$finish;
	end

endmodule
